>>> sv/gsc_pkg.sv
`default_nettype none
package gsc_pkg;
    localparam int MaxZonesDefault = 64;
    localparam int CoordW = 14;
    localparam logic [CoordW-1:0] CoordLimit = 14'd10000;
    localparam logic [CoordW-1:0] DistStart = 14'h3FFF;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ZONE  = 2'd1,
        CMD_WAYPT = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_VALID = 3'd0,
        ST_DUP   = 3'd1,
        ST_HIT   = 3'd2,
        ST_RANGE = 3'd3,
        ST_FULL  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_TEST,
        BK_CMP,
        BK_SQRT,
        BK_OUT
    } t_bk_state;

    typedef struct packed {
        logic             seg;
        t_status          status;
        logic [CoordW-1:0] ax;
        logic [CoordW-1:0] ay;
        logic [CoordW-1:0] bx;
        logic [CoordW-1:0] by;
    } t_job;
endpackage
`default_nettype wire

>>> sv/geofence_segment_checker_top.sv
`default_nettype none
// channel  | direction | tdata fields (low bit up)                 | tuser
// s_axis   | in        | pos_x[13:0] pos_y[27:14] zone_radius[41:28] | command[1:0]
// m_axis   | out       | closest_x[13:0] closest_y[27:14]            | status[2:0]
//          |           | closest_distance[41:28] hit_count[48:42]    |
// A waypoint segment walks the table in the shared test and root unit: each
// zone is read, tested and compared, and a hit zone also takes an integer
// square root (15 steps and a compare). Zone commands and out-of-range or
// repeated waypoints give a result without the walk. Reset is synchronous, active low.
// A new transfer waits until the job queue is empty and the back part idle;
// output holds until taken.
module geofence_segment_checker_top import gsc_pkg::*; #(
    parameter int MaxZones = MaxZonesDefault
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [47:0]  s_axis_tdata,  // pos_x, pos_y, zone_radius
    input  wire [1:0]   s_axis_tuser,  // command
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [55:0] m_axis_tdata,  // closest_x, closest_y, closest_distance, hit_count
    output logic [2:0]  m_axis_tuser   // status
);
    localparam int AW = $clog2(MaxZones);
    localparam int CntW = $clog2(MaxZones+1);

    logic              w_we, w_jv, w_jr, w_bidle;
    logic [AW-1:0]     w_waddr, w_raddr;
    logic [3*CoordW-1:0] w_wdata, w_rdata;
    logic [CntW-1:0]   w_cnt;
    t_job              w_job;
    logic [CoordW-1:0] w_cx, w_cy, w_d;
    logic [6:0]        w_h;

    gsc_front #(.MaxZones(MaxZones)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_cmd(s_axis_tuser), .i_x(s_axis_tdata[13:0]), .i_y(s_axis_tdata[27:14]),
        .i_r(s_axis_tdata[41:28]),
        .o_zone_we(w_we), .o_zone_addr(w_waddr), .o_zone_data(w_wdata),
        .o_zone_count(w_cnt), .o_job_valid(w_jv), .i_job_ready(w_jr),
        .i_back_idle(w_bidle), .o_job(w_job)
    );

    gsc_ram #(.Width(3*CoordW), .Depth(MaxZones)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    gsc_back #(.MaxZones(MaxZones)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(w_jv), .o_job_ready(w_jr), .o_idle(w_bidle), .i_job(w_job),
        .i_zone_count(w_cnt), .o_raddr(w_raddr), .i_rdata(w_rdata),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_status(m_axis_tuser),
        .o_cx(w_cx), .o_cy(w_cy), .o_dist(w_d), .o_hits(w_h)
    );

    assign m_axis_tdata = {7'd0, w_h, w_d, w_cy, w_cx};
endmodule
`default_nettype wire

>>> sv/gsc_ram.sv
`default_nettype none
module gsc_ram #(
    parameter int Width = 42,
    parameter int Depth = 64
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(Depth)-1:0] i_waddr,
    input  wire [Width-1:0]         i_wdata,
    input  wire [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]        o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> sv/gsc_front.sv
`default_nettype none
module gsc_front import gsc_pkg::*; #(
    parameter int MaxZones = MaxZonesDefault
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_ready,
    input  wire [1:0]                  i_cmd,
    input  wire [CoordW-1:0]           i_x,
    input  wire [CoordW-1:0]           i_y,
    input  wire [CoordW-1:0]           i_r,
    output logic                       o_zone_we,
    output logic [$clog2(MaxZones)-1:0] o_zone_addr,
    output logic [3*CoordW-1:0]        o_zone_data,
    output logic [$clog2(MaxZones+1)-1:0] o_zone_count,
    output logic                       o_job_valid,
    input  wire                        i_job_ready,
    input  wire                        i_back_idle,
    output t_job                       o_job
);
    localparam int CntW = $clog2(MaxZones+1);

    logic [CntW-1:0]   r_count;
    logic              r_have;
    logic [CoordW-1:0] r_px, r_py;
    logic              r_jv;
    t_job              r_job;
    t_job              w_job;
    logic              w_emit, w_acc, w_xy_bad, w_r_bad, w_full;
    t_cmd              w_cmd;

    assign w_cmd    = t_cmd'(i_cmd);
    assign o_ready  = !r_jv && i_back_idle;
    assign w_acc    = i_valid && o_ready;
    assign w_xy_bad = (i_x >= CoordLimit) || (i_y >= CoordLimit);
    assign w_r_bad  = i_r >= CoordLimit;
    assign w_full   = r_count >= CntW'(MaxZones);

    always_comb begin
        w_emit = 1'b0;
        w_job = '{seg: 1'b0, status: ST_VALID, ax: r_px, ay: r_py, bx: i_x, by: i_y};
        case (w_cmd)
            CMD_ZONE: begin
                w_emit = 1'b1;
                if (w_xy_bad || w_r_bad) begin
                    w_job.status = ST_RANGE;
                end else if (w_full) begin
                    w_job.status = ST_FULL;
                end
            end
            CMD_WAYPT: begin
                if (w_xy_bad) begin
                    w_emit = 1'b1;
                    w_job.status = ST_RANGE;
                end else if (r_have) begin
                    w_emit = 1'b1;
                    if (i_x == r_px && i_y == r_py) begin
                        w_job.status = ST_DUP;
                    end else begin
                        w_job.seg = 1'b1;
                    end
                end
            end
            default: w_emit = 1'b0;
        endcase
    end

    assign o_zone_we   = w_acc && w_cmd == CMD_ZONE && !w_xy_bad && !w_r_bad && !w_full;
    assign o_zone_addr = r_count[$clog2(MaxZones)-1:0];
    assign o_zone_data = {i_r, i_y, i_x};
    assign o_zone_count = r_count;
    assign o_job_valid = r_jv;
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_have  <= 1'b0;
            r_px    <= '0;
            r_py    <= '0;
            r_jv    <= 1'b0;
        end else begin
            if (w_acc && w_emit) begin
                r_jv <= 1'b1;
            end else if (i_job_ready) begin
                r_jv <= 1'b0;
            end
            if (w_acc) begin
                if (w_emit) begin
                    r_job <= w_job;
                end
                if (w_cmd == CMD_CLEAR) begin
                    r_count <= '0;
                    r_have  <= 1'b0;
                end
                if (o_zone_we) begin
                    r_count <= r_count + 1'b1;
                end
                if (w_cmd == CMD_WAYPT && !w_xy_bad) begin
                    r_have <= 1'b1;
                    if (!r_have || w_job.seg) begin
                        r_px <= i_x;
                        r_py <= i_y;
                    end
                end
            end
        end
    end

    a_full_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MaxZones)) else $error("zone count beyond table");
    a_no_we_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !o_zone_we) else $error("write into full table");
    a_hold_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_jv && !i_job_ready |=> r_jv && $stable(r_job)) else $error("job lost");
endmodule
`default_nettype wire

>>> sv/gsc_back.sv
`default_nettype none
module gsc_back import gsc_pkg::*; #(
    parameter int MaxZones = MaxZonesDefault
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_job_valid,
    output logic                       o_job_ready,
    output logic                       o_idle,
    input  t_job                       i_job,
    input  wire [$clog2(MaxZones+1)-1:0] i_zone_count,
    output logic [$clog2(MaxZones)-1:0] o_raddr,
    input  wire [3*CoordW-1:0]         i_rdata,
    output logic                       o_valid,
    input  wire                        i_ready,
    output logic [2:0]                 o_status,
    output logic [CoordW-1:0]          o_cx,
    output logic [CoordW-1:0]          o_cy,
    output logic [CoordW-1:0]          o_dist,
    output logic [6:0]                 o_hits
);
    localparam int CntW = $clog2(MaxZones+1);
    localparam int AW = $clog2(MaxZones);

    t_bk_state r_st, n_st;
    t_job      r_job;
    logic [CntW-1:0] r_idx;
    logic [CoordW-1:0] r_zx, r_zy;
    logic signed [CoordW+1:0] r_dx, r_dy, r_wx, r_wy, r_ex, r_ey;
    logic [28:0] r_dd, r_ww, r_eb, r_r2;
    logic signed [29:0] r_dot;
    logic        r_hit;
    logic [28:0] r_sv;
    logic [28:0] r_sres, r_sbit;
    logic [CoordW-1:0] r_best, r_bx, r_by;
    logic [6:0]  r_hits;
    logic [3:0]  r_phase;
    logic signed [60:0] r_lhs, r_rhs;
    logic        r_ov;
    logic [2:0]  r_ost;
    logic [CoordW-1:0] r_ocx, r_ocy, r_odist;
    logic [6:0]  r_ohits;

    logic [CoordW-1:0] w_zr;
    logic [28:0] w_sum;

    assign o_job_ready = (r_st == BK_IDLE) && !r_ov;
    assign o_idle      = r_st == BK_IDLE;
    assign o_raddr     = r_idx[AW-1:0];
    assign w_zr        = i_rdata[3*CoordW-1:2*CoordW];
    assign w_sum       = r_sres + r_sbit;
    assign o_valid  = r_ov;
    assign o_status = r_ost;
    assign o_cx     = r_ocx;
    assign o_cy     = r_ocy;
    assign o_dist   = r_odist;
    assign o_hits   = r_ohits;

    always_comb begin
        n_st = r_st;
        case (r_st)
            BK_IDLE: if (i_job_valid && !r_ov) n_st = i_job.seg ? BK_READ : BK_OUT;
            BK_READ: n_st = (r_idx >= i_zone_count) ? BK_OUT : BK_TEST;
            BK_TEST: n_st = (r_phase == 4'd3) ? BK_CMP : BK_TEST;
            BK_CMP:  n_st = r_hit ? BK_SQRT : BK_READ;
            BK_SQRT: n_st = (r_sbit == '0) ? BK_READ : BK_SQRT;
            BK_OUT:  n_st = BK_IDLE;
            default: n_st = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= BK_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == BK_OUT) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            BK_IDLE: begin
                r_job   <= i_job;
                r_idx   <= '0;
                r_hits  <= '0;
                r_best  <= DistStart;
                r_bx    <= '0;
                r_by    <= '0;
                r_phase <= '0;
            end
            BK_READ: begin
                r_phase <= '0;
            end
            BK_TEST: begin
                r_phase <= r_phase + 1'b1;
                case (r_phase)
                    4'd0: begin
                        r_zx <= i_rdata[CoordW-1:0];
                        r_zy <= i_rdata[2*CoordW-1:CoordW];
                        r_dx <= $signed({2'b0, r_job.bx}) - $signed({2'b0, r_job.ax});
                        r_dy <= $signed({2'b0, r_job.by}) - $signed({2'b0, r_job.ay});
                        r_wx <= $signed({2'b0, i_rdata[CoordW-1:0]})
                                - $signed({2'b0, r_job.ax});
                        r_wy <= $signed({2'b0, i_rdata[2*CoordW-1:CoordW]})
                                - $signed({2'b0, r_job.ay});
                        r_ex <= $signed({2'b0, i_rdata[CoordW-1:0]})
                                - $signed({2'b0, r_job.bx});
                        r_ey <= $signed({2'b0, i_rdata[2*CoordW-1:CoordW]})
                                - $signed({2'b0, r_job.by});
                        r_r2 <= 29'(w_zr * w_zr);
                    end
                    4'd1: begin
                        r_dd  <= 29'(r_dx * r_dx + r_dy * r_dy);
                        r_ww  <= 29'(r_wx * r_wx + r_wy * r_wy);
                        r_eb  <= 29'(r_ex * r_ex + r_ey * r_ey);
                        r_dot <= 30'(r_wx * r_dx + r_wy * r_dy);
                    end
                    4'd2: begin
                        r_lhs <= 61'($signed({1'b0, r_ww}) * $signed({1'b0, r_dd}))
                                 - 61'(r_dot * r_dot);
                        r_rhs <= 61'($signed({1'b0, r_r2}) * $signed({1'b0, r_dd}));
                    end
                    default: begin
                        if (r_dot <= 0) begin
                            r_hit <= r_ww <= r_r2;
                        end else if (r_dot >= $signed({1'b0, r_dd})) begin
                            r_hit <= r_eb <= r_r2;
                        end else begin
                            r_hit <= r_lhs <= r_rhs;
                        end
                        r_sv   <= 29'(r_wx * r_wx + r_wy * r_wy);
                        r_sres <= '0;
                        r_sbit <= 29'd1 << 28;
                    end
                endcase
            end
            BK_CMP: begin
                r_idx <= r_idx + 1'b1;
                if (r_hit && r_hits != 7'd127) begin
                    r_hits <= r_hits + 1'b1;
                end
            end
            BK_SQRT: begin
                if (r_sbit != '0) begin
                    if (r_sv >= w_sum) begin
                        r_sv   <= r_sv - w_sum;
                        r_sres <= (r_sres >> 1) + r_sbit;
                    end else begin
                        r_sres <= r_sres >> 1;
                    end
                    r_sbit <= r_sbit >> 2;
                end else if (r_sres[CoordW-1:0] < r_best) begin
                    r_best <= r_sres[CoordW-1:0];
                    r_bx   <= r_zx;
                    r_by   <= r_zy;
                end
            end
            BK_OUT: begin
                if (r_job.seg && r_hits != '0) begin
                    r_ost   <= ST_HIT;
                    r_ocx   <= r_bx;
                    r_ocy   <= r_by;
                    r_odist <= r_best;
                    r_ohits <= r_hits;
                end else begin
                    r_ost   <= r_job.status;
                    r_ocx   <= '0;
                    r_ocy   <= '0;
                    r_odist <= '0;
                    r_ohits <= r_job.seg ? r_hits : 7'd0;
                end
            end
            default: r_phase <= '0;
        endcase
    end

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st != BK_IDLE |-> !o_job_ready) else $error("job taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !i_ready |=> r_ov && $stable(r_ost)) else $error("result dropped");
    a_hit_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_ost == ST_HIT |-> r_ohits != '0) else $error("hit without count");
endmodule
`default_nettype wire
